FILE: rtl/cpe_pkg.sv
// Shared widths, codes and types for the complex polynomial root/evaluation block.
package cpe_pkg;

   localparam int WORD_W    = 32;
   localparam int OP_W      = 2;
   localparam int SLOT_W    = 5;
   localparam int DEG_W     = 5;
   localparam int STATUS_W  = 2;
   localparam int CSR_IDX_W = 2;

   typedef logic signed [WORD_W-1:0] word_type;
   typedef logic [OP_W-1:0]          op_type;
   typedef logic [STATUS_W-1:0]      status_type;
   typedef logic [CSR_IDX_W-1:0]     csr_idx_type;

   localparam op_type OP_WRITE_ROOT = 2'd0;
   localparam op_type OP_EVAL       = 2'd1;
   localparam op_type OP_READ_COEF  = 2'd2;
   localparam op_type OP_READ_ROOT  = 2'd3;

   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_RANGE = 2'd1;
   localparam status_type ST_SAT   = 2'd2;

   localparam csr_idx_type CSR_DEGREE  = 2'd0;
   localparam csr_idx_type CSR_LEAD_RE = 2'd1;
   localparam csr_idx_type CSR_LEAD_IM = 2'd2;

   typedef struct packed {
      logic start;
      logic subtract;
   } cmac_ctl_type;

   typedef struct packed {
      logic done;
      logic sat;
   } cmac_sts_type;

endpackage

FILE: rtl/cpe_if.sv
// Valid/ready channel interfaces: request, response and register write.
interface cpe_req_if;
   import cpe_pkg::*;
   logic                valid;
   logic                ready;
   op_type              op;
   logic [SLOT_W-1:0]   slot;
   word_type            value_re;
   word_type            value_im;
   modport source(output valid, output op, output slot, output value_re, output value_im,
                  input ready);
   modport sink(input valid, input op, input slot, input value_re, input value_im,
                output ready);
endinterface

interface cpe_rsp_if;
   import cpe_pkg::*;
   logic       valid;
   logic       ready;
   word_type   out_re;
   word_type   out_im;
   status_type status;
   modport source(output valid, output out_re, output out_im, output status, input ready);
   modport sink(input valid, input out_re, input out_im, input status, output ready);
endinterface

interface cpe_csr_if;
   import cpe_pkg::*;
   logic        valid;
   logic        ready;
   csr_idx_type index;
   word_type    data;
   modport source(output valid, output index, output data, input ready);
   modport sink(input valid, input index, input data, output ready);
endinterface

FILE: rtl/cpe_ram.sv
// Generic single write port, single read port RAM with registered read data.
module cpe_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                      wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                      rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

FILE: rtl/cpe_cmac.sv
// Shared complex multiply-accumulate: sat(add +/- rnd(a*b)), one real product per cycle.
module cpe_cmac #(
   parameter int FRAC_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cpe_pkg::cmac_ctl_type ctl,
   input  cpe_pkg::word_type     a_re,
   input  cpe_pkg::word_type     a_im,
   input  cpe_pkg::word_type     b_re,
   input  cpe_pkg::word_type     b_im,
   input  cpe_pkg::word_type     add_re,
   input  cpe_pkg::word_type     add_im,
   output cpe_pkg::cmac_sts_type sts,
   output cpe_pkg::word_type     res_re,
   output cpe_pkg::word_type     res_im
);
   import cpe_pkg::*;

   localparam int W     = WORD_W;
   localparam int ACC_W = 2 * W + 3;
   localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC_BITS - 1);
   localparam logic signed [ACC_W-1:0] MAXV = ACC_W'((65'(1) << (W - 1)) - 65'(1));
   localparam logic signed [ACC_W-1:0] MINV = -MAXV - ACC_W'(1);
   localparam logic [2:0] STEP_LAST = 3'd6;

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic                     sat_ff, sat_in;
   logic [2:0]               step_ff, step_in;
   word_type                 ar_ff, ai_ff, br_ff, bi_ff, adr_ff, adi_ff;
   logic                     sub_ff;
   logic signed [2*W-1:0]    prod_ff, prod_in;
   logic signed [ACC_W-1:0]  acc_re_ff, acc_re_in, acc_im_ff, acc_im_in;
   logic signed [ACC_W-1:0]  sum_re, sum_im;
   word_type                 res_re_ff, res_re_in, res_im_ff, res_im_in;
   word_type                 mul_x, mul_y;
   logic                     sat_re, sat_im;

   always_comb begin
      case (step_ff)
         3'd0:    begin mul_x = ar_ff; mul_y = br_ff; end
         3'd1:    begin mul_x = ai_ff; mul_y = bi_ff; end
         3'd2:    begin mul_x = ar_ff; mul_y = bi_ff; end
         default: begin mul_x = ai_ff; mul_y = br_ff; end
      endcase
   end

   // step 6: acc registers hold the rounded parts
   assign sum_re = sub_ff ? ACC_W'(adr_ff) - acc_re_ff : ACC_W'(adr_ff) + acc_re_ff;
   assign sum_im = sub_ff ? ACC_W'(adi_ff) - acc_im_ff : ACC_W'(adi_ff) + acc_im_ff;
   assign sat_re = (sum_re > MAXV) || (sum_re < MINV);
   assign sat_im = (sum_im > MAXV) || (sum_im < MINV);

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      sat_in    = sat_ff;
      step_in   = step_ff;
      prod_in   = mul_x * mul_y;
      acc_re_in = acc_re_ff;
      acc_im_in = acc_im_ff;
      res_re_in = res_re_ff;
      res_im_in = res_im_ff;
      if (busy_ff) begin
         step_in = step_ff + 3'd1;
         case (step_ff)
            3'd1: acc_re_in = ACC_W'(prod_ff);
            3'd2: acc_re_in = acc_re_ff - ACC_W'(prod_ff);
            3'd3: acc_im_in = ACC_W'(prod_ff);
            3'd4: acc_im_in = acc_im_ff + ACC_W'(prod_ff);
            3'd5: begin
               acc_re_in = (acc_re_ff + HALF) >>> FRAC_BITS;
               acc_im_in = (acc_im_ff + HALF) >>> FRAC_BITS;
            end
            STEP_LAST: begin
               res_re_in = sat_re ? (sum_re[ACC_W-1] ? word_type'(MINV) : word_type'(MAXV))
                                  : sum_re[W-1:0];
               res_im_in = sat_im ? (sum_im[ACC_W-1] ? word_type'(MINV) : word_type'(MAXV))
                                  : sum_im[W-1:0];
               sat_in    = sat_re | sat_im;
               done_in   = 1'b1;
               busy_in   = 1'b0;
            end
            default: ;
         endcase
      end else if (ctl.start) begin
         busy_in = 1'b1;
         step_in = 3'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff   <= step_in;
      sat_ff    <= sat_in;
      prod_ff   <= prod_in;
      acc_re_ff <= acc_re_in;
      acc_im_ff <= acc_im_in;
      res_re_ff <= res_re_in;
      res_im_ff <= res_im_in;
      if (!busy_ff && ctl.start) begin
         ar_ff  <= a_re;
         ai_ff  <= a_im;
         br_ff  <= b_re;
         bi_ff  <= b_im;
         adr_ff <= add_re;
         adi_ff <= add_im;
         sub_ff <= ctl.subtract;
      end
   end

   assign sts.done = done_ff;
   assign sts.sat  = sat_ff;
   assign res_re   = res_re_ff;
   assign res_im   = res_im_ff;
endmodule

FILE: rtl/complex_poly_roots_expand_eval.sv
// Complex polynomial from its roots: root store, coefficient expansion, Horner evaluation.
//
// Channels: req_ch takes one beat per item (op, slot, value_re/im); rsp_ch returns exactly
// one beat per item (out_re/im, status); csr_ch writes poly_degree, lead_re, lead_im and is
// always ready, to be used only while the block is idle.
// One item is worked at a time; req_ch.ready is high only in the idle state. Every complex
// multiply-add runs on one shared unit that forms one real 32x32 product per cycle.
// After a root or register change the first evaluation or coefficient read first expands:
// the coefficients from the roots and the lead.
// A finished beat waits in the response register; the block takes the next item meanwhile
// and only holds in its final state if a second result would overwrite an untaken one.
// Reset: all roots read 1.0, degree 0, lead 1.0, coefficients marked for expansion.
module complex_poly_roots_expand_eval #(
   parameter int MAX_DEGREE = 16,
   parameter int FRAC_BITS  = 16
) (
   input logic        clock,
   input logic        reset,
   cpe_req_if.sink    req_ch,
   cpe_rsp_if.source  rsp_ch,
   cpe_csr_if.sink    csr_ch
);
   import cpe_pkg::*;

   localparam int W   = WORD_W;
   localparam int RAW = MAX_DEGREE > 1 ? $clog2(MAX_DEGREE) : 1;
   localparam int CW  = $clog2(MAX_DEGREE + 1);
   localparam int IW  = CW > SLOT_W ? CW : SLOT_W;
   localparam word_type ONE = W'(1) << FRAC_BITS;

   localparam logic [4:0] S_IDLE     = 5'd0;
   localparam logic [4:0] S_DECODE   = 5'd1;
   localparam logic [4:0] S_ROOT_RD  = 5'd2;
   localparam logic [4:0] S_ROOT_GET = 5'd3;
   localparam logic [4:0] S_EI       = 5'd4;
   localparam logic [4:0] S_ER_RD    = 5'd5;
   localparam logic [4:0] S_ER_GET   = 5'd6;
   localparam logic [4:0] S_EJ_CUR   = 5'd7;
   localparam logic [4:0] S_EJ_RD    = 5'd8;
   localparam logic [4:0] S_EJ_GET   = 5'd9;
   localparam logic [4:0] S_EJ_WAIT  = 5'd10;
   localparam logic [4:0] S_L_RD     = 5'd11;
   localparam logic [4:0] S_L_GET    = 5'd12;
   localparam logic [4:0] S_L_WAIT   = 5'd13;
   localparam logic [4:0] S_H_RD     = 5'd14;
   localparam logic [4:0] S_H_GET    = 5'd15;
   localparam logic [4:0] S_H_WAIT   = 5'd16;
   localparam logic [4:0] S_C_RD     = 5'd17;
   localparam logic [4:0] S_C_GET    = 5'd18;
   localparam logic [4:0] S_DONE     = 5'd19;

   logic [4:0]            state_ff, state_in;
   op_type                op_ff, op_in;
   logic [SLOT_W-1:0]     slot_ff, slot_in;
   word_type              val_re_ff, val_re_in, val_im_ff, val_im_in;
   logic [DEG_W-1:0]      degree_ff, degree_in;
   word_type              lead_re_ff, lead_re_in, lead_im_ff, lead_im_in;
   logic                  stale_ff, stale_in;
   logic                  exp_sat_ff, exp_sat_in;
   logic                  sat_acc_ff, sat_acc_in;
   logic [CW-1:0]         idx_ff, idx_in;
   logic [CW-1:0]         root_i_ff, root_i_in;
   word_type              root_re_ff, root_re_in, root_im_ff, root_im_in;
   word_type              cur_re_ff, cur_re_in, cur_im_ff, cur_im_in;
   word_type              prev_re_ff, prev_re_in, prev_im_ff, prev_im_in;
   word_type              res_re_ff, res_re_in, res_im_ff, res_im_in;
   status_type            res_st_ff, res_st_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   word_type              out_re_ff, out_re_in, out_im_ff, out_im_in;
   status_type            out_st_ff, out_st_in;
   logic [MAX_DEGREE-1:0] root_vld_ff, root_vld_in;
   logic                  rd_vld_ff, rd_vld_in;

   logic [IW-1:0]         slot_x, deg_x, n_x;
   logic [CW-1:0]         n_c;

   logic                  root_we;
   logic [RAW-1:0]        root_waddr, root_raddr;
   logic [2*W-1:0]        root_wdata, root_rdata;
   logic                  coef_we;
   logic [CW-1:0]         coef_waddr, coef_raddr;
   logic [2*W-1:0]        coef_wdata, coef_rdata;
   word_type              root_sel_re, root_sel_im, coef_re, coef_im, ej_prev_re, ej_prev_im;

   cmac_ctl_type          mac_ctl;
   cmac_sts_type          mac_sts;
   word_type              mac_a_re, mac_a_im, mac_b_re, mac_b_im, mac_add_re, mac_add_im;
   word_type              mac_re, mac_im;

   assign slot_x = IW'(slot_ff);
   assign deg_x  = IW'(degree_ff);
   assign n_x    = (deg_x > IW'(MAX_DEGREE)) ? IW'(MAX_DEGREE) : deg_x;
   assign n_c    = n_x[CW-1:0];

   assign root_sel_re = rd_vld_ff ? root_rdata[2*W-1:W] : ONE;
   assign root_sel_im = rd_vld_ff ? root_rdata[W-1:0] : '0;
   assign coef_re     = coef_rdata[2*W-1:W];
   assign coef_im     = coef_rdata[W-1:0];
   assign ej_prev_re  = (idx_ff != '0) ? coef_re : '0;
   assign ej_prev_im  = (idx_ff != '0) ? coef_im : '0;

   cpe_ram #(.WIDTH(2 * W), .DEPTH(MAX_DEGREE)) u_root_ram (
      .clock (clock),
      .we    (root_we),
      .waddr (root_waddr),
      .wdata (root_wdata),
      .raddr (root_raddr),
      .rdata (root_rdata)
   );

   cpe_ram #(.WIDTH(2 * W), .DEPTH(MAX_DEGREE + 1)) u_coef_ram (
      .clock (clock),
      .we    (coef_we),
      .waddr (coef_waddr),
      .wdata (coef_wdata),
      .raddr (coef_raddr),
      .rdata (coef_rdata)
   );

   cpe_cmac #(.FRAC_BITS(FRAC_BITS)) u_cmac (
      .clock  (clock),
      .reset  (reset),
      .ctl    (mac_ctl),
      .a_re   (mac_a_re),
      .a_im   (mac_a_im),
      .b_re   (mac_b_re),
      .b_im   (mac_b_im),
      .add_re (mac_add_re),
      .add_im (mac_add_im),
      .sts    (mac_sts),
      .res_re (mac_re),
      .res_im (mac_im)
   );

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      slot_in      = slot_ff;
      val_re_in    = val_re_ff;
      val_im_in    = val_im_ff;
      degree_in    = degree_ff;
      lead_re_in   = lead_re_ff;
      lead_im_in   = lead_im_ff;
      stale_in     = stale_ff;
      exp_sat_in   = exp_sat_ff;
      sat_acc_in   = sat_acc_ff;
      idx_in       = idx_ff;
      root_i_in    = root_i_ff;
      root_re_in   = root_re_ff;
      root_im_in   = root_im_ff;
      cur_re_in    = cur_re_ff;
      cur_im_in    = cur_im_ff;
      prev_re_in   = prev_re_ff;
      prev_im_in   = prev_im_ff;
      res_re_in    = res_re_ff;
      res_im_in    = res_im_ff;
      res_st_in    = res_st_ff;
      rsp_valid_in = rsp_valid_ff;
      out_re_in    = out_re_ff;
      out_im_in    = out_im_ff;
      out_st_in    = out_st_ff;
      root_vld_in  = root_vld_ff;

      root_we    = 1'b0;
      root_waddr = slot_x[RAW-1:0];
      root_wdata = {val_re_ff, val_im_ff};
      root_raddr = root_i_ff[RAW-1:0];
      coef_we    = 1'b0;
      coef_waddr = idx_ff;
      coef_wdata = {mac_re, mac_im};
      coef_raddr = idx_ff;

      mac_ctl    = '0;
      mac_a_re   = cur_re_ff;
      mac_a_im   = cur_im_ff;
      mac_b_re   = root_re_ff;
      mac_b_im   = root_im_ff;
      mac_add_re = ej_prev_re;
      mac_add_im = ej_prev_im;

      if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_DEGREE: begin
               degree_in = csr_ch.data[DEG_W-1:0];
               stale_in  = 1'b1;
            end
            CSR_LEAD_RE: begin
               lead_re_in = csr_ch.data;
               stale_in   = 1'b1;
            end
            CSR_LEAD_IM: begin
               lead_im_in = csr_ch.data;
               stale_in   = 1'b1;
            end
            default: ;
         endcase
      end

      if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               op_in     = req_ch.op;
               slot_in   = req_ch.slot;
               val_re_in = req_ch.value_re;
               val_im_in = req_ch.value_im;
               state_in  = S_DECODE;
            end
         end
         S_DECODE: begin
            sat_acc_in = 1'b0;
            cur_re_in  = '0;
            cur_im_in  = '0;
            res_re_in  = '0;
            res_im_in  = '0;
            res_st_in  = ST_OK;
            case (op_ff)
               OP_WRITE_ROOT: begin
                  if (slot_x < IW'(MAX_DEGREE)) begin
                     root_we                          = 1'b1;
                     root_vld_in[slot_x[RAW-1:0]]     = 1'b1;
                     stale_in                         = 1'b1;
                  end else begin
                     res_st_in = ST_RANGE;
                  end
                  state_in = S_DONE;
               end
               OP_EVAL: begin
                  if (stale_ff) begin
                     idx_in   = '0;
                     state_in = S_EI;
                  end else begin
                     idx_in   = n_c;
                     state_in = S_H_RD;
                  end
               end
               OP_READ_COEF: begin
                  if (slot_x > n_x) begin
                     res_st_in = ST_RANGE;
                     state_in  = S_DONE;
                  end else if (stale_ff) begin
                     idx_in   = '0;
                     state_in = S_EI;
                  end else begin
                     state_in = S_C_RD;
                  end
               end
               default: begin
                  if (slot_x < n_x) begin
                     state_in = S_ROOT_RD;
                  end else begin
                     res_st_in = ST_RANGE;
                     state_in  = S_DONE;
                  end
               end
            endcase
         end
         S_ROOT_RD: begin
            root_raddr = slot_x[RAW-1:0];
            state_in   = S_ROOT_GET;
         end
         S_ROOT_GET: begin
            res_re_in = root_sel_re;
            res_im_in = root_sel_im;
            state_in  = S_DONE;
         end
         S_EI: begin
            coef_we    = 1'b1;
            coef_wdata = (idx_ff == '0) ? {ONE, W'(0)} : '0;
            if (idx_ff == n_c) begin
               idx_in    = '0;
               root_i_in = '0;
               state_in  = (n_c == '0) ? S_L_RD : S_ER_RD;
            end else begin
               idx_in = idx_ff + CW'(1);
            end
         end
         S_ER_RD: begin
            state_in = S_ER_GET;
         end
         S_ER_GET: begin
            root_re_in = root_sel_re;
            root_im_in = root_sel_im;
            coef_raddr = n_c;
            idx_in     = n_c;
            state_in   = S_EJ_CUR;
         end
         S_EJ_CUR: begin
            cur_re_in = coef_re;
            cur_im_in = coef_im;
            state_in  = S_EJ_RD;
         end
         S_EJ_RD: begin
            coef_raddr = idx_ff - CW'(1);
            state_in   = S_EJ_GET;
         end
         S_EJ_GET: begin
            prev_re_in       = ej_prev_re;
            prev_im_in       = ej_prev_im;
            mac_ctl.start    = 1'b1;
            mac_ctl.subtract = 1'b1;
            state_in         = S_EJ_WAIT;
         end
         S_EJ_WAIT: begin
            if (mac_sts.done) begin
               coef_we    = 1'b1;
               sat_acc_in = sat_acc_ff | mac_sts.sat;
               cur_re_in  = prev_re_ff;
               cur_im_in  = prev_im_ff;
               if (idx_ff == '0) begin
                  if (root_i_ff + CW'(1) == n_c) begin
                     state_in = S_L_RD;
                  end else begin
                     root_i_in = root_i_ff + CW'(1);
                     state_in  = S_ER_RD;
                  end
               end else begin
                  idx_in   = idx_ff - CW'(1);
                  state_in = S_EJ_RD;
               end
            end
         end
         S_L_RD: begin
            state_in = S_L_GET;
         end
         S_L_GET: begin
            mac_a_re      = coef_re;
            mac_a_im      = coef_im;
            mac_b_re      = lead_re_ff;
            mac_b_im      = lead_im_ff;
            mac_add_re    = '0;
            mac_add_im    = '0;
            mac_ctl.start = 1'b1;
            state_in      = S_L_WAIT;
         end
         S_L_WAIT: begin
            if (mac_sts.done) begin
               coef_we    = 1'b1;
               sat_acc_in = sat_acc_ff | mac_sts.sat;
               if (idx_ff == n_c) begin
                  stale_in   = 1'b0;
                  exp_sat_in = sat_acc_ff | mac_sts.sat;
                  sat_acc_in = 1'b0;
                  if (op_ff == OP_EVAL) begin
                     idx_in   = n_c;
                     state_in = S_H_RD;
                  end else begin
                     state_in = S_C_RD;
                  end
               end else begin
                  idx_in   = idx_ff + CW'(1);
                  state_in = S_L_RD;
               end
            end
         end
         S_H_RD: begin
            state_in = S_H_GET;
         end
         S_H_GET: begin
            mac_b_re      = val_re_ff;
            mac_b_im      = val_im_ff;
            mac_add_re    = coef_re;
            mac_add_im    = coef_im;
            mac_ctl.start = 1'b1;
            state_in      = S_H_WAIT;
         end
         S_H_WAIT: begin
            if (mac_sts.done) begin
               cur_re_in  = mac_re;
               cur_im_in  = mac_im;
               sat_acc_in = sat_acc_ff | mac_sts.sat;
               if (idx_ff == '0) begin
                  res_re_in = mac_re;
                  res_im_in = mac_im;
                  res_st_in = (sat_acc_ff | mac_sts.sat | exp_sat_ff) ? ST_SAT : ST_OK;
                  state_in  = S_DONE;
               end else begin
                  idx_in   = idx_ff - CW'(1);
                  state_in = S_H_RD;
               end
            end
         end
         S_C_RD: begin
            coef_raddr = slot_x[CW-1:0];
            state_in   = S_C_GET;
         end
         S_C_GET: begin
            res_re_in = coef_re;
            res_im_in = coef_im;
            res_st_in = exp_sat_ff ? ST_SAT : ST_OK;
            state_in  = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               out_re_in    = res_re_ff;
               out_im_in    = res_im_ff;
               out_st_in    = res_st_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      rd_vld_in = root_vld_ff[root_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         degree_ff    <= '0;
         lead_re_ff   <= ONE;
         lead_im_ff   <= '0;
         stale_ff     <= 1'b1;
         exp_sat_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         root_vld_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         degree_ff    <= degree_in;
         lead_re_ff   <= lead_re_in;
         lead_im_ff   <= lead_im_in;
         stale_ff     <= stale_in;
         exp_sat_ff   <= exp_sat_in;
         rsp_valid_ff <= rsp_valid_in;
         root_vld_ff  <= root_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      slot_ff    <= slot_in;
      val_re_ff  <= val_re_in;
      val_im_ff  <= val_im_in;
      sat_acc_ff <= sat_acc_in;
      idx_ff     <= idx_in;
      root_i_ff  <= root_i_in;
      root_re_ff <= root_re_in;
      root_im_ff <= root_im_in;
      cur_re_ff  <= cur_re_in;
      cur_im_ff  <= cur_im_in;
      prev_re_ff <= prev_re_in;
      prev_im_ff <= prev_im_in;
      res_re_ff  <= res_re_in;
      res_im_ff  <= res_im_in;
      res_st_ff  <= res_st_in;
      out_re_ff  <= out_re_in;
      out_im_ff  <= out_im_in;
      out_st_ff  <= out_st_in;
      rd_vld_ff  <= rd_vld_in;
   end

   assign req_ch.ready  = (state_ff == S_IDLE);
   assign csr_ch.ready  = 1'b1;
   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.out_re = out_re_ff;
   assign rsp_ch.out_im = out_im_ff;
   assign rsp_ch.status = out_st_ff;
endmodule
